// ----- src/vmpcg_pkg.sv -----
// Shared types and constants for the video mode pixel color generator.
`default_nettype none
package vmpcg_pkg;

	localparam int unsigned PIX_N = 4;

	typedef logic [7:0] color_t;

	typedef struct packed {
		logic [3:0]       mode;
		logic [3:0][7:0]  bg;
	} cfg_t;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_BG0  = 3'd1;
	localparam logic [2:0] REG_BG1  = 3'd2;
	localparam logic [2:0] REG_BG2  = 3'd3;
	localparam logic [2:0] REG_BG3  = 3'd4;

	localparam logic [2:0] MODE_TEXT   = 3'd0;
	localparam logic [2:0] MODE_MCTEXT = 3'd1;
	localparam logic [2:0] MODE_HIRES  = 3'd2;
	localparam logic [2:0] MODE_MCBMP  = 3'd3;
	localparam logic [2:0] MODE_EXTBG  = 3'd4;

	localparam int unsigned MODE_BIT_NOINV = 3;

	localparam logic [1:0] CODE_BG0  = 2'd0;
	localparam logic [1:0] CODE_HI   = 2'd1;
	localparam logic [1:0] CODE_LO   = 2'd2;
	localparam logic [1:0] CODE_BG1  = 2'd3;

	localparam color_t BG_PENDING = 8'hFF;
	localparam color_t MC_MASK    = 8'h77;

endpackage
`default_nettype wire

// ----- src/vmpcg_lane.sv -----
// One pixel lane: color of the pixel at bit position pos.
`default_nettype none
module vmpcg_lane (
	input  wire vmpcg_pkg::cfg_t   cfg,
	input  wire logic [4:0]        pos,
	input  wire logic [31:0]       attribute_word,
	input  wire logic [31:0]       character_word,
	input  wire logic [31:0]       hires_bits,
	input  wire logic [31:0]       multi_low_bits,
	input  wire logic [31:0]       multi_high_bits,
	input  wire logic [31:0]       cursor_bits,
	input  wire logic              flash_on,
	input  wire logic [3:0]        pend,
	output vmpcg_pkg::color_t      color
);

	logic [7:0] a;
	logic [7:0] c;
	logic [7:0] lo;
	logic [7:0] hi;
	logic [1:0] code;
	logic       b;
	logic       bt;
	logic       cur;

	function automatic vmpcg_pkg::color_t bg_pick(input logic [1:0] idx);
		return pend[idx] ? vmpcg_pkg::BG_PENDING : cfg.bg[idx];
	endfunction

	always_comb begin
		a    = attribute_word[{pos[4:3], 3'b000} +: 8];
		c    = character_word[{pos[4:3], 3'b000} +: 8];
		b    = hires_bits[pos];
		cur  = cursor_bits[pos];
		code = {multi_high_bits[pos], multi_low_bits[pos]};
		lo   = {1'b0, a[6:4], c[3:0]};
		hi   = {1'b0, a[2:0], c[7:4]};
		bt   = b;
		if (cur) begin
			bt = b ^ flash_on;
		end else if (a[7]) begin
			bt = b & flash_on;
		end
		if (!cfg.mode[vmpcg_pkg::MODE_BIT_NOINV] && c[7]) begin
			bt = ~bt;
		end
		case (cfg.mode[2:0])
			vmpcg_pkg::MODE_TEXT: begin
				color = bt ? a : bg_pick(2'd0);
			end
			vmpcg_pkg::MODE_MCTEXT: begin
				if (a[3]) begin
					color = (code == vmpcg_pkg::CODE_BG1) ? (a & vmpcg_pkg::MC_MASK)
						: bg_pick(code);
				end else begin
					color = b ? a : bg_pick(2'd0);
				end
			end
			vmpcg_pkg::MODE_HIRES: begin
				color = b ? hi : lo;
			end
			vmpcg_pkg::MODE_MCBMP: begin
				case (code)
					vmpcg_pkg::CODE_BG0: color = bg_pick(2'd0);
					vmpcg_pkg::CODE_HI:  color = hi;
					vmpcg_pkg::CODE_LO:  color = lo;
					default:             color = bg_pick(2'd1);
				endcase
			end
			vmpcg_pkg::MODE_EXTBG: begin
				color = b ? a : bg_pick(c[7:6]);
			end
			default: begin
				color = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/video_mode_pixel_color_generator.sv -----
// Top level: config registers, four pixel lanes and the merged output register.
//
//  channel | signals                         | direction
//  cfg     | cfg_valid cfg_ready cfg_index   | write, index 0 mode, 1..4 backgrounds
//  in      | in_valid in_ready + item fields | request in
//  out     | out_valid out_ready + pixels    | request out
//
// One request per cycle while in_ready is high; the four lanes are combinational and feed the output register.
// out_valid rises in the cycle after a request is accepted.
// Reset clears the config registers and out_valid.
// in_ready drops only while the output register holds a request that is not taken.
`default_nettype none
module video_mode_pixel_color_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  bit_offset,
	input  wire logic [31:0] attribute_word,
	input  wire logic [31:0] character_word,
	input  wire logic [31:0] hires_bits,
	input  wire logic [31:0] multi_low_bits,
	input  wire logic [31:0] multi_high_bits,
	input  wire logic [31:0] cursor_bits,
	input  wire logic        flash_on,
	input  wire logic [3:0]  write_pending,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       pixel_zero,
	output logic [7:0]       pixel_one,
	output logic [7:0]       pixel_two,
	output logic [7:0]       pixel_three
);

	vmpcg_pkg::cfg_t   cfg_q;
	vmpcg_pkg::color_t lane_color [vmpcg_pkg::PIX_N];
	vmpcg_pkg::color_t pix_q      [vmpcg_pkg::PIX_N];
	logic              out_valid_q;
	logic              in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				vmpcg_pkg::REG_MODE: cfg_q.mode   <= cfg_data[3:0];
				vmpcg_pkg::REG_BG0:  cfg_q.bg[0]  <= cfg_data;
				vmpcg_pkg::REG_BG1:  cfg_q.bg[1]  <= cfg_data;
				vmpcg_pkg::REG_BG2:  cfg_q.bg[2]  <= cfg_data;
				vmpcg_pkg::REG_BG3:  cfg_q.bg[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < vmpcg_pkg::PIX_N; k++) begin : g_lane
		vmpcg_lane u_lane (
			.cfg             (cfg_q),
			.pos             (bit_offset - 5'(k)),
			.attribute_word  (attribute_word),
			.character_word  (character_word),
			.hires_bits      (hires_bits),
			.multi_low_bits  (multi_low_bits),
			.multi_high_bits (multi_high_bits),
			.cursor_bits     (cursor_bits),
			.flash_on        (flash_on),
			.pend            ((k == 0) ? write_pending : 4'b0000),
			.color           (lane_color[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q <= lane_color;
		end
	end

	assign pixel_zero  = pix_q[0];
	assign pixel_one   = pix_q[1];
	assign pixel_two   = pix_q[2];
	assign pixel_three = pix_q[3];

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted request not presented");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !in_fire) |=> !out_valid_q)
		else $error("taken request presented twice");

	a_invalid_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (cfg_q.mode[2:0] > vmpcg_pkg::MODE_EXTBG)) |=>
		(pixel_zero == 8'h00 && pixel_one == 8'h00 && pixel_two == 8'h00
		&& pixel_three == 8'h00))
		else $error("invalid mode produced nonzero pixels");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the video mode pixel color generator: directed and random groups checked against a predictor.
module tb;

	localparam logic [2:0] MODE_NONE = 3'd7;

	typedef struct {
		logic [4:0]  offs;
		logic [31:0] attr;
		logic [31:0] chr;
		logic [31:0] hires;
		logic [31:0] mlo;
		logic [31:0] mhi;
		logic [31:0] cursor;
		logic        flash;
		logic [3:0]  pend;
	} pixel_group_t;

	typedef logic [vmpcg_pkg::PIX_N-1:0][7:0] pixel_set_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [4:0]  bit_offset;
	logic [31:0] attribute_word;
	logic [31:0] character_word;
	logic [31:0] hires_bits;
	logic [31:0] multi_low_bits;
	logic [31:0] multi_high_bits;
	logic [31:0] cursor_bits;
	logic        flash_on;
	logic [3:0]  write_pending;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  pixel_zero;
	logic [7:0]  pixel_one;
	logic [7:0]  pixel_two;
	logic [7:0]  pixel_three;

	pixel_group_t      group_q[$];
	pixel_set_t        expected_pixels_q[$];
	pixel_group_t      queued_group;
	pixel_group_t      taken_group;
	pixel_set_t        got_pixels;
	pixel_set_t        want_pixels;
	vmpcg_pkg::cfg_t   cfg_shadow;
	bit                in_fire;
	bit                cfg_fire;
	bit                held;
	int                idle_odds;
	int                send_gap;
	int                stall_left;
	int                hold_left;
	int                n_taken;
	int                n_queued;
	int                n_errors;

	video_mode_pixel_color_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.bit_offset(bit_offset),
		.attribute_word(attribute_word),
		.character_word(character_word),
		.hires_bits(hires_bits),
		.multi_low_bits(multi_low_bits),
		.multi_high_bits(multi_high_bits),
		.cursor_bits(cursor_bits),
		.flash_on(flash_on),
		.write_pending(write_pending),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_zero(pixel_zero),
		.pixel_one(pixel_one),
		.pixel_two(pixel_two),
		.pixel_three(pixel_three)
	);

	always #1 clk = ~clk;

	function automatic vmpcg_pkg::color_t bg_color(input logic [1:0] idx, input bit first,
			input logic [3:0] pend);
		return (first && pend[idx]) ? vmpcg_pkg::BG_PENDING : cfg_shadow.bg[idx];
	endfunction

	function automatic vmpcg_pkg::color_t lane_color(input pixel_group_t g,
			input logic [4:0] p, input bit first);
		vmpcg_pkg::color_t a;
		vmpcg_pkg::color_t c;
		vmpcg_pkg::color_t lo;
		vmpcg_pkg::color_t hi;
		logic              b;
		logic [1:0]        code;
		a = g.attr[8*p[4:3] +: 8];
		c = g.chr[8*p[4:3] +: 8];
		b = g.hires[p];
		code = {g.mhi[p], g.mlo[p]};
		lo = (a & 8'h70) | (c & 8'h0F);
		hi = {1'b0, a[2:0], c[7:4]};
		case (cfg_shadow.mode[2:0])
			vmpcg_pkg::MODE_TEXT: begin
				if (g.cursor[p])
					b = b ^ g.flash;
				else if (a[7])
					b = b & g.flash;
				if (!cfg_shadow.mode[vmpcg_pkg::MODE_BIT_NOINV] && c[7])
					b = !b;
				return b ? a : bg_color(2'd0, first, g.pend);
			end
			vmpcg_pkg::MODE_MCTEXT: begin
				if (a[3]) begin
					if (code == vmpcg_pkg::CODE_BG1)
						return a & vmpcg_pkg::MC_MASK;
					return bg_color(code, first, g.pend);
				end
				return b ? a : bg_color(2'd0, first, g.pend);
			end
			vmpcg_pkg::MODE_HIRES:
				return b ? hi : lo;
			vmpcg_pkg::MODE_MCBMP: begin
				case (code)
					vmpcg_pkg::CODE_BG0: return bg_color(2'd0, first, g.pend);
					vmpcg_pkg::CODE_HI:  return hi;
					vmpcg_pkg::CODE_LO:  return lo;
					default:             return bg_color(2'd1, first, g.pend);
				endcase
			end
			vmpcg_pkg::MODE_EXTBG:
				return b ? a : bg_color(c[7:6], first, g.pend);
			default:
				return '0;
		endcase
	endfunction

	function automatic pixel_set_t predict_pixels(input pixel_group_t g);
		pixel_set_t quad;
		logic [4:0] p;
		for (int k = 0; k < vmpcg_pkg::PIX_N; k++) begin
			p = g.offs - 5'(k);
			quad[k] = lane_color(g, p, k == 0);
		end
		return quad;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_fire)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (group_q.size() != 0 || in_valid || expected_pixels_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// advance the pixel source
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_fire && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
				send_gap = $urandom_range(1, 16);
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (group_q.size() != 0) begin
				queued_group = group_q.pop_front();
				bit_offset <= queued_group.offs;
				attribute_word <= queued_group.attr;
				character_word <= queued_group.chr;
				hires_bits <= queued_group.hires;
				multi_low_bits <= queued_group.mlo;
				multi_high_bits <= queued_group.mhi;
				cursor_bits <= queued_group.cursor;
				flash_on <= queued_group.flash;
				write_pending <= queued_group.pend;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// hold the pixel sink off once for a long stretch, otherwise stall in bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held && n_taken >= 400 && group_q.size() > 20) begin
				held = 1'b1;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				stall_left = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			cfg_fire <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					vmpcg_pkg::REG_MODE: cfg_shadow.mode = cfg_data[3:0];
					vmpcg_pkg::REG_BG0:  cfg_shadow.bg[0] = cfg_data;
					vmpcg_pkg::REG_BG1:  cfg_shadow.bg[1] = cfg_data;
					vmpcg_pkg::REG_BG2:  cfg_shadow.bg[2] = cfg_data;
					vmpcg_pkg::REG_BG3:  cfg_shadow.bg[3] = cfg_data;
					default:  ;
				endcase
			end
			if (out_valid && out_ready) begin
				got_pixels[0] = pixel_zero;
				got_pixels[1] = pixel_one;
				got_pixels[2] = pixel_two;
				got_pixels[3] = pixel_three;
				if (expected_pixels_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected pixels %h %h %h %h", pixel_zero, pixel_one,
							pixel_two, pixel_three);
				end else begin
					want_pixels = expected_pixels_q.pop_front();
					if (got_pixels !== want_pixels) begin
						n_errors++;
						if (n_errors <= 10)
							$display("pixel mismatch: expected %h %h %h %h got %h %h %h %h",
								want_pixels[0], want_pixels[1], want_pixels[2],
								want_pixels[3], pixel_zero, pixel_one, pixel_two,
								pixel_three);
					end
				end
			end
			if (in_valid && in_ready) begin
				taken_group.offs = bit_offset;
				taken_group.attr = attribute_word;
				taken_group.chr = character_word;
				taken_group.hires = hires_bits;
				taken_group.mlo = multi_low_bits;
				taken_group.mhi = multi_high_bits;
				taken_group.cursor = cursor_bits;
				taken_group.flash = flash_on;
				taken_group.pend = write_pending;
				expected_pixels_q.push_back(predict_pixels(taken_group));
				n_taken++;
			end
		end
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		pixel_group_t dir_groups[2];
		pixel_group_t g;
		logic [2:0]   kinds[6];
		logic [3:0]   mode;
		int           n_phase;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = vmpcg_pkg::REG_MODE;
		cfg_data = '0;
		in_valid = 1'b0;
		bit_offset = 5'd3;
		attribute_word = '0;
		character_word = '0;
		hires_bits = '0;
		multi_low_bits = '0;
		multi_high_bits = '0;
		cursor_bits = '0;
		flash_on = 1'b0;
		write_pending = '0;
		out_ready = 1'b0;
		cfg_shadow = '0;
		idle_odds = 0;
		dir_groups[0] = '{5'd31, 32'hFF08_80F8, 32'hC080_40FF, 32'hA5A5_5A5A,
			32'h0F0F_F0F0, 32'h3333_CCCC, 32'h6666_9999, 1'b1, 4'hF};
		dir_groups[1] = '{5'd8, 32'h0077_88F0, 32'h00FF_7F80, 32'h0000_0155,
			32'h0000_00F0, 32'h0000_01CC, 32'h0000_0111, 1'b0, 4'h5};
		kinds = '{vmpcg_pkg::MODE_TEXT, vmpcg_pkg::MODE_MCTEXT, vmpcg_pkg::MODE_HIRES,
			vmpcg_pkg::MODE_MCBMP, vmpcg_pkg::MODE_EXTBG, MODE_NONE};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(vmpcg_pkg::REG_BG0, 8'h12);
		write_reg(vmpcg_pkg::REG_BG1, 8'h34);
		write_reg(vmpcg_pkg::REG_BG2, 8'h56);
		write_reg(vmpcg_pkg::REG_BG3, 8'h78);
		for (int noinv = 0; noinv < 2; noinv++) begin
			foreach (kinds[i]) begin
				write_reg(vmpcg_pkg::REG_MODE, 8'({noinv[0], kinds[i]}));
				group_q.push_back(dir_groups[0]);
				group_q.push_back(dir_groups[1]);
				n_queued += 2;
				wait_drained();
			end
		end

		while (n_queued < 1750) begin
			mode = 4'($urandom_range(0, 15));
			if (mode[2:0] > vmpcg_pkg::MODE_EXTBG && $urandom_range(0, 3) != 0)
				mode[2:0] = 3'($urandom_range(0, 4));
			write_reg(vmpcg_pkg::REG_MODE, 8'(mode));
			for (int i = 0; i < 4; i++)
				write_reg(3'(vmpcg_pkg::REG_BG0 + i), 8'(($urandom_range(0, 3) == 0) ?
					($urandom_range(0, 1) ? 8'hFF : 8'h00) : $urandom_range(0, 255)));
			idle_odds = (n_queued >= 1500 || $urandom_range(0, 3) == 0) ? 0 :
				$urandom_range(2, 8);
			n_phase = $urandom_range(40, 160);
			for (int i = 0; i < n_phase; i++) begin
				g.offs = 5'($urandom_range(3, 31));
				g.attr = rand_word();
				g.chr = rand_word();
				g.hires = rand_word();
				g.mlo = rand_word();
				g.mhi = rand_word();
				g.cursor = rand_word();
				g.flash = 1'($urandom_range(0, 1));
				g.pend = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
				group_q.push_back(g);
			end
			n_queued += n_phase;
			wait_drained();
		end

		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
